// ===== src/tkck_pkg.sv =====
// Package for the top-k cost keeper: shared types, item kinds and register indexes.
// Used by tkck_cell and top_k_cost_keeper; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package tkck_pkg;

	typedef logic signed [31:0] cost_t;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_DRAIN  = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

	localparam logic CFG_KEEP_COUNT = 1'b0;
	localparam logic CFG_BATCH_SIZE = 1'b1;

	localparam logic [3:0]  KEEP_COUNT_RESET = 4'd8;
	localparam logic [15:0] BATCH_SIZE_RESET = 16'd64;

	// Control broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic  ins;   // store the new word at its rank, shift the tail right
		logic  shift; // drain step: every cell takes its right neighbor
		cost_t cost;  // cost of the word being inserted
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/tkck_cell.sv =====
// One cell of the sorted chain: holds one kept entry and compares it with the new cost.
// Depends on tkck_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tkck_cell
	import tkck_pkg::*;
#(
	parameter int IDX     = 0,
	parameter int ID_BITS = 8,
	parameter int PW      = 4
) (
	input  wire logic               clk,
	input  wire cell_ctl_t          ctl,
	input  wire logic [ID_BITS-1:0] ins_id,
	input  wire logic [PW-1:0]      fill,
	input  wire logic               left_lt,
	input  wire cost_t              left_cost,
	input  wire logic [ID_BITS-1:0] left_id,
	input  wire cost_t              right_cost,
	input  wire logic [ID_BITS-1:0] right_id,
	input  wire logic [ID_BITS-1:0] drop_in,
	output logic                    lt,
	output cost_t                   cost_out,
	output logic [ID_BITS-1:0]      id_out,
	output logic [ID_BITS-1:0]      drop_out
);

	cost_t              cost_q;
	logic [ID_BITS-1:0] id_q;
	logic               valid;
	logic               tail;
	logic               ins_here;
	logic               take_left;

	assign valid = PW'(IDX) < fill;
	assign lt    = valid && (cost_q < ctl.cost);

	// The strictly-lower cells form a prefix, so the rank boundary is where lt falls.
	assign ins_here  = left_lt && !lt;
	assign take_left = !left_lt;

	// The last occupied cell passes its id down the chain as the push-out candidate.
	assign tail     = PW'(IDX + 1) == fill;
	assign drop_out = drop_in | (tail ? id_q : '0);

	assign cost_out = cost_q;
	assign id_out   = id_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (ins_here) begin
				cost_q <= ctl.cost;
				id_q   <= ins_id;
			end else if (take_left) begin
				cost_q <= left_cost;
				id_q   <= left_id;
			end
		end else if (ctl.shift) begin
			cost_q <= right_cost;
			id_q   <= right_id;
		end
	end

endmodule
`default_nettype wire

// ===== src/top_k_cost_keeper.sv =====
// Top level of the top-k cost keeper: sequencer, counters, registers and the cell chain.
// Depends on tkck_pkg and tkck_cell.
//
//  channel  | handshake             | word
//  ---------+-----------------------+----------------------------------------------
//  command  | start, busy           | kind, cost, sample_id
//  config   | cfg_valid, cfg_ready  | cfg_index, cfg_data
//  result   | strobe                | accepted, position, dropped_valid, dropped_id,
//           |                       | batch_done, out_valid, out_id, out_cost, last
//
// Insert and clear give their result on the cycle after the accepting edge, and a new
// command can be taken on that same cycle. A drain of n kept entries shifts the chain
// toward cell 0 once per cycle and gives max(n,1) results on consecutive cycles; busy
// is raised only for n above one and drops as the last result word appears.
// Reset empties the list and the count and loads keep_count 8, batch_size 64.
// The receiver cannot stall results; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module top_k_cost_keeper
	import tkck_pkg::*;
#(
	parameter int MAX_KEEP = 8,
	parameter int ID_BITS  = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    kind,
	input  wire cost_t                         cost,
	input  wire logic [ID_BITS-1:0]            sample_id,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [15:0]                   cfg_data,
	output logic                               strobe,
	output logic                               accepted,
	output logic [$clog2(MAX_KEEP + 1)-1:0]    position,
	output logic                               dropped_valid,
	output logic [ID_BITS-1:0]                 dropped_id,
	output logic                               batch_done,
	output logic                               out_valid,
	output logic [ID_BITS-1:0]                 out_id,
	output cost_t                              out_cost,
	output logic                               last
);

	localparam int PW = $clog2(MAX_KEEP + 1);
	localparam int CW = (PW > 4) ? PW : 4;

	state_t        state_q, state_d;
	logic [PW-1:0] fill_q, fill_d;
	logic [PW-1:0] left_q, left_d;
	logic [15:0]   cnt_q, cnt_d, cnt_inc;
	logic [3:0]    keep_q;
	logic [15:0]   batch_q;

	cell_ctl_t ctl;

	logic [MAX_KEEP-1:0] lt_vec;
	cost_t               cell_cost [MAX_KEEP];
	logic [ID_BITS-1:0]  cell_id   [MAX_KEEP];
	logic [ID_BITS-1:0]  drop_chain [MAX_KEEP+1];
	logic [PW-1:0]       rank;
	logic [CW-1:0]       keep_eff;
	logic                rank_fits;
	logic                full;

	logic               strobe_d, acc_d, dv_d, bd_d, ov_d, last_d;
	logic [PW-1:0]      pos_d;
	logic [ID_BITS-1:0] did_d, oid_d;
	cost_t              oc_d;

	assign busy      = state_q == ST_DRAIN;
	assign cfg_ready = 1'b1;

	// Cell chain.
	assign drop_chain[0] = '0;
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		logic               l_lt;
		cost_t              l_cost;
		logic [ID_BITS-1:0] l_id;
		cost_t              r_cost;
		logic [ID_BITS-1:0] r_id;

		if (i == 0) begin : g_head
			assign l_lt   = 1'b1;
			assign l_cost = '0;
			assign l_id   = '0;
		end else begin : g_body
			assign l_lt   = lt_vec[i-1];
			assign l_cost = cell_cost[i-1];
			assign l_id   = cell_id[i-1];
		end
		if (i == MAX_KEEP - 1) begin : g_end
			assign r_cost = '0;
			assign r_id   = '0;
		end else begin : g_mid
			assign r_cost = cell_cost[i+1];
			assign r_id   = cell_id[i+1];
		end

		tkck_cell #(
			.IDX    (i),
			.ID_BITS(ID_BITS),
			.PW     (PW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.ins_id    (sample_id),
			.fill      (fill_q),
			.left_lt   (l_lt),
			.left_cost (l_cost),
			.left_id   (l_id),
			.right_cost(r_cost),
			.right_id  (r_id),
			.drop_in   (drop_chain[i]),
			.lt        (lt_vec[i]),
			.cost_out  (cell_cost[i]),
			.id_out    (cell_id[i]),
			.drop_out  (drop_chain[i+1])
		);
	end

	assign rank = PW'($countones(lt_vec));

	always_comb begin
		if (CW'(keep_q) > CW'(MAX_KEEP)) begin
			keep_eff = CW'(MAX_KEEP);
		end else begin
			keep_eff = CW'(keep_q);
		end
	end

	assign rank_fits = CW'(rank) < keep_eff;
	assign full      = CW'(fill_q) >= keep_eff;
	assign cnt_inc   = cnt_q + 16'd1;

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		left_d    = left_q;
		cnt_d     = cnt_q;
		ctl.ins   = 1'b0;
		ctl.shift = 1'b0;
		ctl.cost  = cost;
		strobe_d  = 1'b0;
		acc_d     = 1'b0;
		pos_d     = '0;
		dv_d      = 1'b0;
		did_d     = '0;
		bd_d      = 1'b0;
		ov_d      = 1'b0;
		oid_d     = '0;
		oc_d      = '0;
		last_d    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (kind)
						KIND_INSERT: begin
							strobe_d = 1'b1;
							last_d   = 1'b1;
							pos_d    = rank;
							if (rank_fits) begin
								ctl.ins = 1'b1;
								acc_d   = 1'b1;
								// A full list keeps its fill and loses its old last entry.
								if (full) begin
									dv_d  = 1'b1;
									did_d = drop_chain[MAX_KEEP];
								end else begin
									fill_d = fill_q + PW'(1);
								end
							end else begin
								dv_d  = 1'b1;
								did_d = sample_id;
							end
							if (cnt_inc == batch_q) begin
								bd_d  = 1'b1;
								cnt_d = '0;
							end else begin
								cnt_d = cnt_inc;
							end
						end
						KIND_CLEAR: begin
							strobe_d = 1'b1;
							last_d   = 1'b1;
							fill_d   = '0;
							cnt_d    = '0;
						end
						KIND_DRAIN: begin
							strobe_d = 1'b1;
							fill_d   = '0;
							cnt_d    = '0;
							if (fill_q == '0) begin
								last_d = 1'b1;
							end else begin
								ov_d      = 1'b1;
								oid_d     = cell_id[0];
								oc_d      = cell_cost[0];
								ctl.shift = 1'b1;
								if (fill_q == PW'(1)) begin
									last_d = 1'b1;
								end else begin
									state_d = ST_DRAIN;
									left_d  = fill_q - PW'(1);
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DRAIN: begin
				strobe_d  = 1'b1;
				ov_d      = 1'b1;
				oid_d     = cell_id[0];
				oc_d      = cell_cost[0];
				ctl.shift = 1'b1;
				left_d    = left_q - PW'(1);
				if (left_q == PW'(1)) begin
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			left_q  <= '0;
			cnt_q   <= '0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			left_q  <= left_d;
			cnt_q   <= cnt_d;
			strobe  <= strobe_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q  <= KEEP_COUNT_RESET;
			batch_q <= BATCH_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEEP_COUNT: keep_q  <= cfg_data[3:0];
				CFG_BATCH_SIZE: batch_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		accepted      <= acc_d;
		position      <= pos_d;
		dropped_valid <= dv_d;
		dropped_id    <= did_d;
		batch_done    <= bd_d;
		out_valid     <= ov_d;
		out_id        <= oid_d;
		out_cost      <= oc_d;
		last          <= last_d;
	end

	// The chain stays sorted: the cells below the new cost form an unbroken prefix.
	a_sorted_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((lt_vec + MAX_KEEP'(1)) & lt_vec) == '0)
		else $error("cell chain lost its sort order");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= PW'(MAX_KEEP))
		else $error("fill count beyond chain length");

	a_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_INSERT || kind == KIND_CLEAR
			|| kind == KIND_DRAIN)) |=> strobe)
		else $error("accepted command gave no result");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && left_q == PW'(1)) |=> (strobe && last && !busy))
		else $error("drain did not end with a last word");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !out_valid) |-> last)
		else $error("single-word result without last");

endmodule
`default_nettype wire

// ===== bench/top_k_cost_keeper_test.sv =====
// Self-checking testbench for the top-k cost keeper: directed table, then randomized words.
// Depends on tkck_pkg and top_k_cost_keeper; predicts every result word in the bench itself.
`timescale 1ns / 1ps
module top_k_cost_keeper_test;
	import tkck_pkg::*;

	localparam int MAX_KEEP = 8;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic        accepted;
		logic [3:0]  position;
		logic        dropped_valid;
		logic [7:0]  dropped_id;
		logic        batch_done;
		logic        out_valid;
		logic [7:0]  out_id;
		cost_t       out_cost;
		logic        last;
	} outcome_t;

	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  k;
		cost_t       c;
		logic [7:0]  id;
		logic        reg_idx;
		logic [15:0] reg_val;
		logic        typed;
		outcome_t    want;
	} plan_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = KIND_INSERT;
	cost_t       cost = '0;
	logic [7:0]  sample_id = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_KEEP_COUNT;
	logic [15:0] cfg_data = '0;
	logic        strobe;
	logic        accepted;
	logic [3:0]  position;
	logic        dropped_valid;
	logic [7:0]  dropped_id;
	logic        batch_done;
	logic        out_valid;
	logic [7:0]  out_id;
	cost_t       out_cost;
	logic        last;

	top_k_cost_keeper dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .cost(cost), .sample_id(sample_id),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .strobe(strobe), .accepted(accepted), .position(position),
		.dropped_valid(dropped_valid), .dropped_id(dropped_id), .batch_done(batch_done),
		.out_valid(out_valid), .out_id(out_id), .out_cost(out_cost), .last(last)
	);

	// Predicted state of the kept list; one spare slot holds the entry being pushed out.
	cost_t       list_cost [0:MAX_KEEP];
	logic [7:0]  list_id [0:MAX_KEEP];
	int          list_fill = 0;
	logic [15:0] eval_count = '0;
	logic [3:0]  keep_setting = KEEP_COUNT_RESET;
	logic [15:0] batch_setting = BATCH_SIZE_RESET;

	outcome_t    pending_outcomes [$];
	outcome_t    fresh_outcomes [$];
	plan_row_t   plan [$];
	int          mismatch_count = 0;
	int          sender_idle_pct = 25;
	outcome_t    seen_outcome;
	outcome_t    due_outcome;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Some tests failed");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Works out the result words of one command word and updates the predicted list.
	task automatic advance_kept_list(input logic [1:0] k, input cost_t c, input logic [7:0] id);
		int i;
		int rank;
		int keep;
		outcome_t o;
		fresh_outcomes.delete();
		o = '0;
		keep = (keep_setting > MAX_KEEP) ? MAX_KEEP : int'(keep_setting);
		case (k)
			KIND_INSERT: begin
				rank = 0;
				for (i = 0; i < list_fill; i++)
					if (list_cost[i] < c)
						rank++;
				o.position = rank[3:0];
				if (rank < keep) begin
					for (i = list_fill; i > rank; i--) begin
						list_cost[i] = list_cost[i-1];
						list_id[i] = list_id[i-1];
					end
					list_cost[rank] = c;
					list_id[rank] = id;
					list_fill++;
					o.accepted = 1'b1;
					if (list_fill > keep) begin
						list_fill--;
						o.dropped_valid = 1'b1;
						o.dropped_id = list_id[list_fill];
					end
				end else begin
					o.dropped_valid = 1'b1;
					o.dropped_id = id;
				end
				eval_count = eval_count + 16'd1;
				if (eval_count == batch_setting) begin
					o.batch_done = 1'b1;
					eval_count = '0;
				end
				o.last = 1'b1;
				fresh_outcomes = {fresh_outcomes, o};
			end
			KIND_CLEAR: begin
				list_fill = 0;
				eval_count = '0;
				o.last = 1'b1;
				fresh_outcomes = {fresh_outcomes, o};
			end
			KIND_DRAIN: begin
				if (list_fill == 0) begin
					o.last = 1'b1;
					fresh_outcomes = {fresh_outcomes, o};
				end
				for (i = 0; i < list_fill; i++) begin
					o = '0;
					o.out_valid = 1'b1;
					o.out_id = list_id[i];
					o.out_cost = list_cost[i];
					o.last = (i == list_fill - 1);
					fresh_outcomes = {fresh_outcomes, o};
				end
				list_fill = 0;
				eval_count = '0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_word(input logic [1:0] k, input cost_t c, input logic [7:0] id,
			input logic typed, input outcome_t want);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		cost <= c;
		sample_id <= id;
		do @(posedge clk); while (busy !== 1'b0);
		advance_kept_list(k, c, id);
		if (typed)
			pending_outcomes = {pending_outcomes, want};
		else
			pending_outcomes = {pending_outcomes, fresh_outcomes};
	endtask

	// Waits until the block is idle; an unused kind leaves nothing to wait for, so
	// spare cycles follow.
	task automatic settle();
		start <= 1'b0;
		while (pending_outcomes.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		if (idx == CFG_KEEP_COUNT)
			keep_setting = val[3:0];
		else
			batch_setting = val;
	endtask

	function automatic void add_word(input logic [1:0] k, input cost_t c, input logic [7:0] id,
			input logic typed, input outcome_t want);
		plan_row_t row;
		row = '0;
		row.k = k;
		row.c = c;
		row.id = id;
		row.typed = typed;
		row.want = want;
		plan = {plan, row};
	endfunction

	function automatic void add_setting(input logic idx, input logic [15:0] val);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		plan = {plan, row};
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe !== 1'b0) begin
			seen_outcome = {accepted, position, dropped_valid, dropped_id, batch_done,
				out_valid, out_id, out_cost, last};
			if (pending_outcomes.size() == 0) begin
				note_mismatch($sformatf("result word with none expected: %h", seen_outcome));
			end else begin
				due_outcome = pending_outcomes.pop_front();
				if (seen_outcome.accepted !== due_outcome.accepted)
					note_mismatch($sformatf("accepted %b, expected %b",
						seen_outcome.accepted, due_outcome.accepted));
				if (seen_outcome.position !== due_outcome.position)
					note_mismatch($sformatf("position %0d, expected %0d",
						seen_outcome.position, due_outcome.position));
				if (seen_outcome.dropped_valid !== due_outcome.dropped_valid)
					note_mismatch($sformatf("dropped_valid %b, expected %b",
						seen_outcome.dropped_valid, due_outcome.dropped_valid));
				if (seen_outcome.dropped_id !== due_outcome.dropped_id)
					note_mismatch($sformatf("dropped_id %h, expected %h",
						seen_outcome.dropped_id, due_outcome.dropped_id));
				if (seen_outcome.batch_done !== due_outcome.batch_done)
					note_mismatch($sformatf("batch_done %b, expected %b",
						seen_outcome.batch_done, due_outcome.batch_done));
				if (seen_outcome.out_valid !== due_outcome.out_valid)
					note_mismatch($sformatf("out_valid %b, expected %b",
						seen_outcome.out_valid, due_outcome.out_valid));
				if (seen_outcome.out_id !== due_outcome.out_id)
					note_mismatch($sformatf("out_id %h, expected %h",
						seen_outcome.out_id, due_outcome.out_id));
				if (seen_outcome.out_cost !== due_outcome.out_cost)
					note_mismatch($sformatf("out_cost %h, expected %h",
						seen_outcome.out_cost, due_outcome.out_cost));
				if (seen_outcome.last !== due_outcome.last)
					note_mismatch($sformatf("last %b, expected %b",
						seen_outcome.last, due_outcome.last));
			end
		end
	end

	initial begin : main_seq
		int regime;
		int episode;
		int sent;
		int pick;
		int guard;
		logic [1:0] k;
		cost_t c;
		logic [3:0] keep_pick;
		logic [15:0] batch_pick;
		outcome_t only_last;
		outcome_t first_insert;

		only_last = '0;
		only_last.last = 1'b1;
		first_insert = only_last;
		first_insert.accepted = 1'b1;

		// Default settings first: extremes of cost and id, a tie, an ignored kind.
		add_word(KIND_INSERT, 32'sh0000_0000, 8'h11, 1'b1, first_insert);
		add_word(KIND_INSERT, 32'sh7FFF_FFFF, 8'hFF, 1'b0, '0);
		add_word(KIND_INSERT, 32'sh8000_0000, 8'h00, 1'b0, '0);
		add_word(KIND_INSERT, 32'sh0000_0000, 8'h22, 1'b0, '0);
		add_word(KIND_INSERT, 32'shFFFF_FFFF, 8'h33, 1'b0, '0);
		add_word(KIND_UNUSED, 32'sh0005_0000, 8'h44, 1'b0, '0);
		add_word(KIND_DRAIN, '0, '0, 1'b0, '0);
		add_word(KIND_DRAIN, '0, '0, 1'b1, only_last);
		// Small list and short batch: a reject that completes the batch, then a push-out.
		add_setting(CFG_KEEP_COUNT, 16'd2);
		add_setting(CFG_BATCH_SIZE, 16'd3);
		add_word(KIND_INSERT, 32'sh0005_0000, 8'h01, 1'b0, '0);
		add_word(KIND_INSERT, 32'sh0003_0000, 8'h02, 1'b0, '0);
		add_word(KIND_INSERT, 32'sh0009_0000, 8'h03, 1'b0, '0);
		add_word(KIND_INSERT, 32'sh0001_0000, 8'h04, 1'b0, '0);
		add_setting(CFG_KEEP_COUNT, 16'd0);
		add_word(KIND_INSERT, 32'sh0007_0000, 8'h05, 1'b0, '0);
		// Keep count above the list size, batch size zero.
		add_setting(CFG_KEEP_COUNT, 16'hFFFF);
		add_setting(CFG_BATCH_SIZE, 16'd0);
		add_word(KIND_INSERT, 32'sh0002_0000, 8'h06, 1'b0, '0);
		add_word(KIND_INSERT, 32'sh0003_0000, 8'h07, 1'b0, '0);
		// Keep count lowered below the fill: each accepted insert pushes out one entry.
		add_setting(CFG_KEEP_COUNT, 16'd1);
		add_word(KIND_INSERT, 32'sh0000_0000, 8'h08, 1'b0, '0);
		add_word(KIND_INSERT, 32'sh0004_0000, 8'h09, 1'b0, '0);
		add_word(KIND_CLEAR, '0, '0, 1'b1, only_last);
		add_word(KIND_INSERT, 32'sh8000_0000, 8'hAA, 1'b0, '0);
		add_word(KIND_DRAIN, '0, '0, 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].is_cfg)
				write_reg(plan[r].reg_idx, plan[r].reg_val);
			else
				send_word(plan[r].k, plan[r].c, plan[r].id, plan[r].typed, plan[r].want);
		end

		for (regime = 0; regime < 3; regime++) begin
			sender_idle_pct = (regime == 0) ? 25 : (regime == 1) ? 74 : 0;
			for (episode = 0; episode < 5; episode++) begin
				case (episode)
					0: keep_pick = 4'd8;
					1: keep_pick = 4'd1;
					2: keep_pick = (regime == 1) ? 4'd0 : 4'd15;
					3: keep_pick = 4'($urandom_range(0, 15));
					default: keep_pick = 4'($urandom_range(2, 7));
				endcase
				case (episode)
					0: batch_pick = 16'($urandom_range(1, 4));
					1: batch_pick = 16'd1;
					2: batch_pick = (regime == 0) ? 16'hFFFF :
						(regime == 1) ? 16'd0 : 16'($urandom_range(2, 9));
					3: batch_pick = 16'($urandom_range(1, 12));
					default: batch_pick = 16'($urandom_range(2, 6));
				endcase
				// Upper data bits of the keep count write carry noise the block must drop.
				write_reg(CFG_KEEP_COUNT, 16'(($urandom() & 32'hFFF0) | keep_pick));
				write_reg(CFG_BATCH_SIZE, batch_pick);
				sent = 0;
				while (sent < 20) begin
					pick = $urandom_range(0, 99);
					k = (pick < 72) ? KIND_INSERT : (pick < 84) ? KIND_DRAIN :
						(pick < 92) ? KIND_CLEAR : KIND_UNUSED;
					pick = $urandom_range(0, 9);
					if (pick < 5) begin
						// Few distinct values, so equal costs are common.
						c = $urandom_range(0, 12) * 32'sh0001_0000 - 32'sh0006_0000;
					end else if (pick < 7) begin
						case ($urandom_range(0, 3))
							0: c = 32'sh8000_0000;
							1: c = 32'sh7FFF_FFFF;
							2: c = 32'sh0000_0000;
							default: c = 32'shFFFF_FFFF;
						endcase
					end else begin
						c = $urandom();
					end
					send_word(k, c, 8'($urandom_range(0, 255)), 1'b0, '0);
					if (k != KIND_UNUSED)
						sent++;
				end
			end
		end

		start <= 1'b0;
		guard = 0;
		while (pending_outcomes.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (12) @(posedge clk);
		if (pending_outcomes.size() != 0)
			note_mismatch($sformatf("%0d result words never arrived",
				pending_outcomes.size()));
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/tkck_pkg.sv
src/tkck_cell.sv
src/top_k_cost_keeper.sv
bench/top_k_cost_keeper_test.sv
